@@ sv/small_array_table_engine_assert.svh @@
// ----------------------------------------------------------------------------
// small_array_table_engine_assert.svh
// Assertion macros used by the table engine datapath.
// ----------------------------------------------------------------------------
`ifndef SMALL_ARRAY_TABLE_ENGINE_ASSERT_SVH
`define SMALL_ARRAY_TABLE_ENGINE_ASSERT_SVH

// Check a property on every rising clock edge outside of reset.
`define SATE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SATE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

@@ sv/sate_pkg.sv @@
// ----------------------------------------------------------------------------
// sate_pkg
// Sizes, codes and controller/datapath interface types of the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sate_pkg;

   // table geometry
   localparam int DEPTH = 8;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   // field widths
   localparam int DW       = 32;
   localparam int TYPE_W   = 2;
   localparam int POS_W    = 3;
   localparam int STATUS_W = 3;
   localparam int FOUND_W  = 4;
   localparam int PCW      = (POS_W > CW) ? POS_W : CW;

   // stream words
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;
   localparam int REQ_PAD_W   = REQ_TDATA_W - DW - POS_W;
   localparam int RSP_PAD_W   = RSP_TDATA_W - DW - FOUND_W;

   typedef enum logic [TYPE_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_SORT   = 2'd2,
      REQ_SEARCH = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_BAD_POS   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INSERT,
      S_DEL_CHK,
      S_DEL_CAP,
      S_DEL_MOVE,
      S_DEL_DONE,
      S_SRT_START,
      S_SRT_LDI,
      S_SRT_CMP,
      S_SRT_WRI,
      S_SRT_EPRE,
      S_SRT_EMIT,
      S_SCH_START,
      S_SCH_CMP,
      S_SCH_HIT,
      S_SCH_MISS
   } state_type;

   // read address source
   typedef enum logic [2:0] {
      RA_ZERO,
      RA_I,
      RA_I1,
      RA_I2,
      RA_J1,
      RA_POS
   } rd_sel_type;

   // write operation
   typedef enum logic [2:0] {
      WR_NONE,
      WR_APPEND,
      WR_SHIFT,
      WR_SWAP,
      WR_CUR_I
   } wr_op_type;

   typedef enum logic [1:0] {
      I_HOLD,
      I_ZERO,
      I_POS,
      I_INC
   } i_op_type;

   typedef enum logic [1:0] {
      J_HOLD,
      J_I1,
      J_INC
   } j_op_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_RD,
      CUR_MIN
   } cur_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      ED_ZERO,
      ED_CUR,
      ED_RD
   } emit_data_type;

   // controller to datapath
   typedef struct packed {
      logic          latch;
      rd_sel_type    rd_sel;
      wr_op_type     wr_op;
      i_op_type      i_op;
      j_op_type      j_op;
      cur_op_type    cur_op;
      cnt_op_type    cnt_op;
      logic          emit_en;
      status_type    emit_status;
      emit_data_type emit_data;
      logic          emit_found;
      logic          emit_last_cmp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;
      logic count_gt1;
      logic full;
      logic pos_bad;
      logic i1_lt_count;
      logic i2_lt_count;
      logic j1_lt_count;
      logic match;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

@@ sv/small_array_table_engine.sv @@
// ----------------------------------------------------------------------------
// small_array_table_engine
// Small table of signed 32-bit entries with insert, delete, sort and search.
//
// One request word is taken at a time; the next is accepted once the last
// result of the current one is in the output register, so a result may wait
// on rsp_tready while the next request is already being worked on. Delete,
// search and sort are paced by the single registered read port of the entry
// memory, which the sequencer walks one entry per cycle; a sort delivers its
// result words one per cycle while rsp_tready does not stall the output. The
// sort keeps the running minimum in a holding register, so each compare needs
// only one read. Entries beyond the fill count are never used, so the memory
// needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module small_array_table_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_tdata: item_value[31:0], del_position[34:32], zero pad
   input  logic [sate_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_tuser: req_type[1:0]
   input  logic [sate_pkg::TYPE_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata: data_out[31:0], found_position[35:32], zero pad
   output logic [sate_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // rsp_tuser: status[2:0]
   output logic [sate_pkg::STATUS_W-1:0]     rsp_tuser,
   output logic                              rsp_tlast
);

   sate_pkg::cmd_type cmd;
   sate_pkg::sts_type sts;

   // sequencer
   sate_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   // storage and compare
   sate_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_tdata[sate_pkg::DW-1:0]),
      .req_pos    (req_tdata[sate_pkg::DW +: sate_pkg::POS_W]),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ sv/sate_datapath.sv @@
// ----------------------------------------------------------------------------
// sate_datapath
// Entry memory, fill count, walk indexes, compare logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "small_array_table_engine_assert.svh"

module sate_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sate_pkg::DW-1:0]             req_value,
   input  logic [sate_pkg::POS_W-1:0]          req_pos,
   input  sate_pkg::cmd_type                   cmd,
   output sate_pkg::sts_type                   sts,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata: data_out[31:0], found_position[35:32], zero pad
   output logic [sate_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // rsp_tuser: status[2:0]
   output logic [sate_pkg::STATUS_W-1:0]       rsp_tuser,
   output logic                                rsp_tlast
);

   logic [sate_pkg::DW-1:0]       mem [sate_pkg::DEPTH];
   logic signed [sate_pkg::DW-1:0] rd_data_ff;
   logic [sate_pkg::AW-1:0]       rd_addr;
   logic                          wr_en;
   logic [sate_pkg::AW-1:0]       wr_addr;
   logic [sate_pkg::DW-1:0]       wr_data;

   logic [sate_pkg::CW-1:0]       count_ff, count_in;
   logic [sate_pkg::CW-1:0]       i_ff, i_in;
   logic [sate_pkg::CW-1:0]       j_ff, j_in;
   logic signed [sate_pkg::DW-1:0] cur_ff, cur_in;
   logic [sate_pkg::DW-1:0]       value_ff;
   logic [sate_pkg::POS_W-1:0]    pos_ff;

   logic [sate_pkg::CW:0]         i_p1, i_p2, j_p1, count_x;
   logic                          gt;
   logic                          out_free;

   logic                          rsp_valid_ff;
   logic [sate_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [sate_pkg::DW-1:0]       rsp_data_ff;
   logic [sate_pkg::FOUND_W-1:0]  rsp_found_ff;
   logic                          rsp_last_ff;

   // index arithmetic, one bit wider than the count
   assign i_p1    = {1'b0, i_ff} + 1'b1;
   assign i_p2    = {1'b0, i_ff} + 2'd2;
   assign j_p1    = {1'b0, j_ff} + 1'b1;
   assign count_x = {1'b0, count_ff};
   assign gt      = cur_ff > rd_data_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // status to controller
   always_comb begin
      sts.count_zero  = (count_ff == '0);
      sts.count_gt1   = (count_ff > sate_pkg::CW'(1));
      sts.full        = (count_ff == sate_pkg::CW'(sate_pkg::DEPTH));
      sts.pos_bad     = (sate_pkg::PCW'(pos_ff) >= sate_pkg::PCW'(count_ff));
      sts.i1_lt_count = (i_p1 < count_x);
      sts.i2_lt_count = (i_p2 < count_x);
      sts.j1_lt_count = (j_p1 < count_x);
      sts.match       = (rd_data_ff == value_ff);
      sts.out_free    = out_free;
   end

   // select read address
   always_comb begin
      unique case (cmd.rd_sel)
         sate_pkg::RA_I:   rd_addr = i_ff[sate_pkg::AW-1:0];
         sate_pkg::RA_I1:  rd_addr = i_p1[sate_pkg::AW-1:0];
         sate_pkg::RA_I2:  rd_addr = i_p2[sate_pkg::AW-1:0];
         sate_pkg::RA_J1:  rd_addr = j_p1[sate_pkg::AW-1:0];
         sate_pkg::RA_POS: rd_addr = sate_pkg::AW'(pos_ff);
         default:          rd_addr = '0;
      endcase
   end

   // select write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = i_ff[sate_pkg::AW-1:0];
      wr_data = cur_ff;
      unique case (cmd.wr_op)
         sate_pkg::WR_APPEND: begin
            wr_en   = 1'b1;
            wr_addr = count_ff[sate_pkg::AW-1:0];
            wr_data = value_ff;
         end
         sate_pkg::WR_SHIFT: begin
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
         end
         sate_pkg::WR_SWAP: begin
            wr_en   = gt;
            wr_addr = j_ff[sate_pkg::AW-1:0];
         end
         sate_pkg::WR_CUR_I: begin
            wr_en   = 1'b1;
         end
         default: begin
            wr_en   = 1'b0;
         end
      endcase
   end

   // entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // next values of counters and holding register
   always_comb begin
      unique case (cmd.cnt_op)
         sate_pkg::CNT_INC: count_in = count_ff + 1'b1;
         sate_pkg::CNT_DEC: count_in = count_ff - 1'b1;
         default:           count_in = count_ff;
      endcase
      unique case (cmd.i_op)
         sate_pkg::I_ZERO: i_in = '0;
         sate_pkg::I_POS:  i_in = sate_pkg::CW'(pos_ff);
         sate_pkg::I_INC:  i_in = i_p1[sate_pkg::CW-1:0];
         default:          i_in = i_ff;
      endcase
      unique case (cmd.j_op)
         sate_pkg::J_I1:  j_in = i_p1[sate_pkg::CW-1:0];
         sate_pkg::J_INC: j_in = j_p1[sate_pkg::CW-1:0];
         default:         j_in = j_ff;
      endcase
      unique case (cmd.cur_op)
         sate_pkg::CUR_RD:  cur_in = rd_data_ff;
         sate_pkg::CUR_MIN: cur_in = gt ? rd_data_ff : cur_ff;
         default:           cur_in = cur_ff;
      endcase
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // walk indexes, holding register, request fields
   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      cur_ff <= cur_in;
      if (cmd.latch) begin
         value_ff <= req_value;
         pos_ff   <= req_pos;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_en) begin
         rsp_status_ff <= cmd.emit_status;
         unique case (cmd.emit_data)
            sate_pkg::ED_CUR: rsp_data_ff <= cur_ff;
            sate_pkg::ED_RD:  rsp_data_ff <= rd_data_ff;
            default:          rsp_data_ff <= '0;
         endcase
         rsp_found_ff <= cmd.emit_found ? sate_pkg::FOUND_W'(i_p1) : '0;
         rsp_last_ff  <= cmd.emit_last_cmp ? !sts.i1_lt_count : 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{sate_pkg::RSP_PAD_W{1'b0}}, rsp_found_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   `SATE_ASSERT(a_count_in_range, count_ff <= sate_pkg::CW'(sate_pkg::DEPTH), "fill count beyond depth")
   `SATE_ASSERT(a_emit_when_free, cmd.emit_en |-> out_free, "result written over a waiting word")
   `SATE_ASSERT(a_count_steps, (cmd.cnt_op == sate_pkg::CNT_INC) |=> (count_ff == $past(count_ff) + 1'b1), "fill count did not advance")

endmodule

`default_nettype wire

@@ sv/sate_controller.sv @@
// ----------------------------------------------------------------------------
// sate_controller
// Sequencer that walks the table for insert, delete, sort and search.
// ----------------------------------------------------------------------------
`default_nettype none

module sate_controller (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [sate_pkg::TYPE_W-1:0]  req_kind,
   input  sate_pkg::sts_type            sts,
   output sate_pkg::cmd_type            cmd
);

   sate_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sate_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in          = state_ff;
      req_tready        = 1'b0;
      cmd.latch         = 1'b0;
      cmd.rd_sel        = sate_pkg::RA_ZERO;
      cmd.wr_op         = sate_pkg::WR_NONE;
      cmd.i_op          = sate_pkg::I_HOLD;
      cmd.j_op          = sate_pkg::J_HOLD;
      cmd.cur_op        = sate_pkg::CUR_HOLD;
      cmd.cnt_op        = sate_pkg::CNT_HOLD;
      cmd.emit_en       = 1'b0;
      cmd.emit_status   = sate_pkg::ST_OK;
      cmd.emit_data     = sate_pkg::ED_ZERO;
      cmd.emit_found    = 1'b0;
      cmd.emit_last_cmp = 1'b0;

      unique case (state_ff)
         // take a request word and dispatch on its kind
         sate_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               unique case (sate_pkg::req_kind_type'(req_kind))
                  sate_pkg::REQ_INSERT: state_in = sate_pkg::S_INSERT;
                  sate_pkg::REQ_DELETE: state_in = sate_pkg::S_DEL_CHK;
                  sate_pkg::REQ_SORT:   state_in = sate_pkg::S_SRT_START;
                  default:              state_in = sate_pkg::S_SCH_START;
               endcase
            end
         end

         // append or report full
         sate_pkg::S_INSERT: begin
            if (sts.out_free) begin
               cmd.emit_en = 1'b1;
               state_in    = sate_pkg::S_IDLE;
               if (sts.full) begin
                  cmd.emit_status = sate_pkg::ST_FULL;
               end else begin
                  cmd.wr_op  = sate_pkg::WR_APPEND;
                  cmd.cnt_op = sate_pkg::CNT_INC;
               end
            end
         end

         // check for an empty table and the position, fetch the victim
         sate_pkg::S_DEL_CHK: begin
            priority if (sts.count_zero) begin
               if (sts.out_free) begin
                  cmd.emit_en     = 1'b1;
                  cmd.emit_status = sate_pkg::ST_EMPTY;
                  state_in        = sate_pkg::S_IDLE;
               end
            end else if (sts.pos_bad) begin
               if (sts.out_free) begin
                  cmd.emit_en     = 1'b1;
                  cmd.emit_status = sate_pkg::ST_BAD_POS;
                  state_in        = sate_pkg::S_IDLE;
               end
            end else begin
               cmd.rd_sel = sate_pkg::RA_POS;
               cmd.i_op   = sate_pkg::I_POS;
               state_in   = sate_pkg::S_DEL_CAP;
            end
         end

         // hold the removed value, start the shift
         sate_pkg::S_DEL_CAP: begin
            cmd.cur_op = sate_pkg::CUR_RD;
            if (sts.i1_lt_count) begin
               cmd.rd_sel = sate_pkg::RA_I1;
               state_in   = sate_pkg::S_DEL_MOVE;
            end else begin
               state_in   = sate_pkg::S_DEL_DONE;
            end
         end

         // move one later entry down per cycle
         sate_pkg::S_DEL_MOVE: begin
            cmd.wr_op  = sate_pkg::WR_SHIFT;
            cmd.i_op   = sate_pkg::I_INC;
            cmd.rd_sel = sate_pkg::RA_I2;
            if (!sts.i2_lt_count) begin
               state_in = sate_pkg::S_DEL_DONE;
            end
         end

         sate_pkg::S_DEL_DONE: begin
            if (sts.out_free) begin
               cmd.emit_en   = 1'b1;
               cmd.emit_data = sate_pkg::ED_CUR;
               cmd.cnt_op    = sate_pkg::CNT_DEC;
               state_in      = sate_pkg::S_IDLE;
            end
         end

         // sort: empty check, fetch first entry
         sate_pkg::S_SRT_START: begin
            cmd.i_op = sate_pkg::I_ZERO;
            priority if (sts.count_zero) begin
               if (sts.out_free) begin
                  cmd.emit_en     = 1'b1;
                  cmd.emit_status = sate_pkg::ST_EMPTY;
                  state_in        = sate_pkg::S_IDLE;
               end
            end else if (sts.count_gt1) begin
               state_in = sate_pkg::S_SRT_LDI;
            end else begin
               state_in = sate_pkg::S_SRT_EPRE;
            end
         end

         // load entry i into the holding register, fetch entry i+1
         sate_pkg::S_SRT_LDI: begin
            cmd.cur_op = sate_pkg::CUR_RD;
            cmd.j_op   = sate_pkg::J_I1;
            cmd.rd_sel = sate_pkg::RA_I1;
            state_in   = sate_pkg::S_SRT_CMP;
         end

         // compare with entry j, swap when greater, fetch j+1
         sate_pkg::S_SRT_CMP: begin
            cmd.wr_op  = sate_pkg::WR_SWAP;
            cmd.cur_op = sate_pkg::CUR_MIN;
            if (sts.j1_lt_count) begin
               cmd.j_op   = sate_pkg::J_INC;
               cmd.rd_sel = sate_pkg::RA_J1;
            end else begin
               state_in   = sate_pkg::S_SRT_WRI;
            end
         end

         // store the minimum back at i, advance the outer pass
         sate_pkg::S_SRT_WRI: begin
            cmd.wr_op = sate_pkg::WR_CUR_I;
            if (sts.i2_lt_count) begin
               cmd.i_op   = sate_pkg::I_INC;
               cmd.rd_sel = sate_pkg::RA_I1;
               state_in   = sate_pkg::S_SRT_LDI;
            end else begin
               state_in   = sate_pkg::S_SRT_EPRE;
            end
         end

         sate_pkg::S_SRT_EPRE: begin
            cmd.i_op   = sate_pkg::I_ZERO;
            cmd.rd_sel = sate_pkg::RA_ZERO;
            state_in   = sate_pkg::S_SRT_EMIT;
         end

         // emit entries in order; re-read on a stall
         sate_pkg::S_SRT_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_en       = 1'b1;
               cmd.emit_data     = sate_pkg::ED_RD;
               cmd.emit_last_cmp = 1'b1;
               if (sts.i1_lt_count) begin
                  cmd.i_op   = sate_pkg::I_INC;
                  cmd.rd_sel = sate_pkg::RA_I1;
               end else begin
                  state_in   = sate_pkg::S_IDLE;
               end
            end else begin
               cmd.rd_sel = sate_pkg::RA_I;
            end
         end

         // search: fetch first entry
         sate_pkg::S_SCH_START: begin
            cmd.i_op = sate_pkg::I_ZERO;
            if (sts.count_zero) begin
               state_in = sate_pkg::S_SCH_MISS;
            end else begin
               state_in = sate_pkg::S_SCH_CMP;
            end
         end

         sate_pkg::S_SCH_CMP: begin
            priority if (sts.match) begin
               state_in = sate_pkg::S_SCH_HIT;
            end else if (sts.i1_lt_count) begin
               cmd.i_op   = sate_pkg::I_INC;
               cmd.rd_sel = sate_pkg::RA_I1;
            end else begin
               state_in   = sate_pkg::S_SCH_MISS;
            end
         end

         sate_pkg::S_SCH_HIT: begin
            if (sts.out_free) begin
               cmd.emit_en    = 1'b1;
               cmd.emit_found = 1'b1;
               state_in       = sate_pkg::S_IDLE;
            end
         end

         sate_pkg::S_SCH_MISS: begin
            if (sts.out_free) begin
               cmd.emit_en     = 1'b1;
               cmd.emit_status = sate_pkg::ST_NOT_FOUND;
               state_in        = sate_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = sate_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire
